// ----- sv/wsd_pkg.sv -----
// Shared constants, codes and types for the work-stealing task deques.
`timescale 1ns / 1ps
`default_nettype none
package wsd_pkg;
   localparam int LANE_W     = 6;
   localparam int SLOT_W     = 6;
   localparam int CNT_W      = SLOT_W + 1;
   localparam int TASK_W     = 12;
   localparam int LANES      = 1 << LANE_W;
   localparam int SLOTS      = 1 << SLOT_W;
   localparam int RING_DEPTH = LANES * SLOTS;
   localparam int SEED_W     = 64;
   localparam int ACT_W      = 7;
   localparam int DIVIDEND_W = SEED_W - 33;

   localparam logic [SEED_W-1:0] LCG_MUL   = 64'd6364136223846793005;
   localparam logic [SEED_W-1:0] LCG_ADD   = 64'd1442695040888963407;
   localparam logic [SEED_W-1:0] SEED_BASE = 64'h9e3779b97f4a7c15;
   localparam logic [ACT_W-1:0]  ACT_RESET = 7'd2;
   localparam logic [ACT_W-1:0]  ACT_MAX   = ACT_W'(LANES);

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_STEAL = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_TAKE, S_LCG, S_SCAN_RD, S_SCAN_CHK, S_FIN
   } wsd_state_type;

   typedef enum logic [2:0] {
      L_IDLE, L_M0, L_M1, L_M2, L_SUM, L_DIV, L_DONE
   } lcg_state_type;

   typedef struct packed {
      logic [SEED_W-1:0] seed;
      logic [LANE_W-1:0] offset;
   } lcg_res_type;
endpackage
`default_nettype wire

// ----- sv/work_stealing_task_deques.sv -----
// Top level: per-lane ring deques with push, pop and randomized steal.
//
// Input items arrive on req_* (operation, lane_index, task_handle); each gives
// exactly one result item on rsp_* (status, result_task, source_lane).
// csr_* writes active_lanes (reset 2) and is always ready.
// After reset a clearing pass over all 64 lanes zeroes the lane counters and
// loads the steal seeds; req_tready stays low during it.
// From accept, a push or a failed pop passes the look-up state and then the
// finish state; a pop that finds a handle also passes the take state. A steal
// advances the seed through the multiply states and a sum state, reduces its
// top 31 bits modulo the lane count one bit per cycle, then scans victim
// lanes with one counter RAM read each.
// One item is in work at a time. The result sits in an output register; a
// stalled receiver holds it there while the next item may already be taken,
// and that item waits at completion until the register frees.
// Counters live in a 64-entry RAM, handles in a 4096-entry RAM and seeds in a
// 64-entry RAM, all with registered read.
`timescale 1ns / 1ps
`default_nettype none
module work_stealing_task_deques (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // operation, lane_index, task_handle, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // status, result_task, source_lane, zero pad
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data     // active_lanes
);
   localparam int LW = wsd_pkg::LANE_W;
   localparam int CW = wsd_pkg::CNT_W;
   localparam int TW = wsd_pkg::TASK_W;

   wsd_pkg::wsd_state_type state_ff, state_in;
   logic [wsd_pkg::ACT_W-1:0]  act_ff;
   logic [1:0]                 op_ff, op_in;
   logic [LW-1:0]              lane_ff, lane_in;
   logic [TW-1:0]              handle_ff, handle_in;
   logic [LW-1:0]              victim_ff, victim_in;
   logic [CW-1:0]              step_ff, step_in;
   logic [1:0]                 status_ff, status_in;
   logic [TW-1:0]              task_ff, task_in;
   logic [LW-1:0]              src_ff, src_in;
   logic [LW-1:0]              clr_ff;
   logic [wsd_pkg::SEED_W-1:0] acc_ff;
   logic                       rsp_valid_ff;
   logic [23:0]                rsp_data_ff;

   logic                       cnt_we;
   logic [LW-1:0]              cnt_waddr, cnt_raddr;
   logic [2*CW-1:0]            cnt_wdata, cnt_rdata;
   logic                       ring_we;
   logic [LW+wsd_pkg::SLOT_W-1:0] ring_waddr, ring_raddr;
   logic [TW-1:0]              ring_rdata;
   logic                       seed_we;
   logic [LW-1:0]              seed_waddr;
   logic [wsd_pkg::SEED_W-1:0] seed_wdata, seed_rdata;

   logic                       lcg_start, lcg_done;
   wsd_pkg::lcg_res_type       lcg_res;

   logic [CW-1:0]              top_c, bot_c, occ, lanes_eff;
   logic [CW-1:0]              victim_inc;
   logic                       out_free, req_acc;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == wsd_pkg::S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign top_c      = cnt_rdata[CW-1:0];
   assign bot_c      = cnt_rdata[2*CW-1:CW];
   assign occ        = bot_c - top_c;
   assign lanes_eff  = (act_ff > wsd_pkg::ACT_MAX) ? wsd_pkg::ACT_MAX : act_ff;
   assign victim_inc = {1'b0, victim_ff} + CW'(1);

   wsd_ram #(.WIDTH(2 * CW), .DEPTH(wsd_pkg::LANES)) u_cnt_ram (
      .clock, .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
   );

   wsd_ram #(.WIDTH(TW), .DEPTH(wsd_pkg::RING_DEPTH)) u_ring_ram (
      .clock, .wr_en(ring_we), .wr_addr(ring_waddr), .wr_data(handle_ff),
      .rd_addr(ring_raddr), .rd_data(ring_rdata)
   );

   wsd_ram #(.WIDTH(wsd_pkg::SEED_W), .DEPTH(wsd_pkg::LANES)) u_seed_ram (
      .clock, .wr_en(seed_we), .wr_addr(seed_waddr), .wr_data(seed_wdata),
      .rd_addr(lane_in), .rd_data(seed_rdata)
   );

   wsd_lcg u_lcg (
      .clock, .reset, .start(lcg_start), .seed_in(seed_rdata),
      .lanes_in(lanes_eff), .done(lcg_done), .result(lcg_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsd_pkg::S_CLEAR;
         act_ff       <= wsd_pkg::ACT_RESET;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         acc_ff       <= wsd_pkg::SEED_BASE;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            act_ff <= csr_data;
         end
         if (state_ff == wsd_pkg::S_CLEAR) begin
            clr_ff <= clr_ff + LW'(1);
            acc_ff <= acc_ff + wsd_pkg::SEED_BASE;
         end
         if (state_ff == wsd_pkg::S_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == wsd_pkg::S_FIN && out_free) begin
         rsp_data_ff <= {4'd0, src_ff, task_ff, status_ff};
      end
      op_ff     <= op_in;
      lane_ff   <= lane_in;
      handle_ff <= handle_in;
      victim_ff <= victim_in;
      step_ff   <= step_in;
      status_ff <= status_in;
      task_ff   <= task_in;
      src_ff    <= src_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      lane_in    = lane_ff;
      handle_in  = handle_ff;
      victim_in  = victim_ff;
      step_in    = step_ff;
      status_in  = status_ff;
      task_in    = task_ff;
      src_in     = src_ff;
      cnt_we     = 1'b0;
      cnt_waddr  = lane_ff;
      cnt_wdata  = cnt_rdata;
      cnt_raddr  = lane_ff;
      ring_we    = 1'b0;
      ring_waddr = {lane_ff, bot_c[wsd_pkg::SLOT_W-1:0]};
      ring_raddr = {lane_ff, top_c[wsd_pkg::SLOT_W-1:0]};
      seed_we    = 1'b0;
      seed_waddr = lane_ff;
      seed_wdata = lcg_res.seed;
      lcg_start  = 1'b0;
      unique case (state_ff)
         wsd_pkg::S_CLEAR: begin
            cnt_we     = 1'b1;
            cnt_waddr  = clr_ff;
            cnt_wdata  = '0;
            seed_we    = 1'b1;
            seed_waddr = clr_ff;
            seed_wdata = acc_ff;
            if (clr_ff == LW'(wsd_pkg::LANES - 1)) begin
               state_in = wsd_pkg::S_IDLE;
            end
         end
         wsd_pkg::S_IDLE: begin
            if (req_acc) begin
               op_in     = req_tdata[1:0];
               lane_in   = req_tdata[7:2];
               handle_in = req_tdata[19:8];
               cnt_raddr = req_tdata[7:2];
               state_in  = wsd_pkg::S_LOOK;
            end
         end
         wsd_pkg::S_LOOK: begin
            status_in = wsd_pkg::ST_EMPTY;
            task_in   = '0;
            src_in    = '0;
            state_in  = wsd_pkg::S_FIN;
            unique case (op_ff)
               wsd_pkg::OP_PUSH: begin
                  if (occ[CW-1]) begin
                     status_in = wsd_pkg::ST_FULL;
                  end else begin
                     ring_we   = 1'b1;
                     cnt_we    = 1'b1;
                     cnt_wdata = {bot_c + CW'(1), top_c};
                     status_in = wsd_pkg::ST_DONE;
                  end
               end
               wsd_pkg::OP_POP: begin
                  if (occ == CW'(1)) begin
                     cnt_we    = 1'b1;
                     cnt_wdata = {bot_c, top_c + CW'(1)};
                     src_in    = lane_ff;
                     state_in  = wsd_pkg::S_TAKE;
                  end else if (occ != '0) begin
                     // newest item sits one below bottom
                     cnt_we     = 1'b1;
                     cnt_wdata  = {bot_c - CW'(1), top_c};
                     ring_raddr = {lane_ff, 6'(bot_c - CW'(1))};
                     src_in     = lane_ff;
                     state_in   = wsd_pkg::S_TAKE;
                  end
               end
               wsd_pkg::OP_STEAL: begin
                  if (lanes_eff >= CW'(2)) begin
                     lcg_start = 1'b1;
                     state_in  = wsd_pkg::S_LCG;
                  end
               end
               default: ;
            endcase
         end
         wsd_pkg::S_TAKE: begin
            task_in   = ring_rdata;
            status_in = wsd_pkg::ST_DONE;
            state_in  = wsd_pkg::S_FIN;
         end
         wsd_pkg::S_LCG: begin
            if (lcg_done) begin
               seed_we   = 1'b1;
               victim_in = lcg_res.offset;
               step_in   = '0;
               state_in  = wsd_pkg::S_SCAN_RD;
            end
         end
         wsd_pkg::S_SCAN_RD: begin
            cnt_raddr = victim_ff;
            if (step_ff == lanes_eff) begin
               state_in = wsd_pkg::S_FIN;
            end else if (victim_ff == lane_ff) begin
               step_in   = step_ff + CW'(1);
               victim_in = (victim_inc == lanes_eff) ? '0 : victim_inc[LW-1:0];
            end else begin
               state_in = wsd_pkg::S_SCAN_CHK;
            end
         end
         wsd_pkg::S_SCAN_CHK: begin
            cnt_waddr  = victim_ff;
            ring_raddr = {victim_ff, top_c[wsd_pkg::SLOT_W-1:0]};
            if (occ == '0) begin
               step_in   = step_ff + CW'(1);
               victim_in = (victim_inc == lanes_eff) ? '0 : victim_inc[LW-1:0];
               state_in  = wsd_pkg::S_SCAN_RD;
            end else begin
               cnt_we    = 1'b1;
               cnt_wdata = {bot_c, top_c + CW'(1)};
               src_in    = victim_ff;
               state_in  = wsd_pkg::S_TAKE;
            end
         end
         wsd_pkg::S_FIN: begin
            if (out_free) begin
               state_in = wsd_pkg::S_IDLE;
            end
         end
         default: state_in = wsd_pkg::S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ----- sv/wsd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module wsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- sv/wsd_lcg.sv -----
// Seed advance (split 64-bit multiply) and bit-serial modulo for the steal start lane.
`timescale 1ns / 1ps
`default_nettype none
module wsd_lcg (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [wsd_pkg::SEED_W-1:0]  seed_in,
   input  wire logic [wsd_pkg::ACT_W-1:0]   lanes_in,
   output logic                             done,
   output wsd_pkg::lcg_res_type             result
);
   wsd_pkg::lcg_state_type state_ff, state_in;
   logic [wsd_pkg::SEED_W-1:0]     seed_ff, seed_in_r;
   logic [63:0]                    p0_ff, p0_in;
   logic [31:0]                    p1_ff, p1_in, p2_ff, p2_in;
   logic [wsd_pkg::ACT_W-1:0]      lanes_ff, lanes_in_r;
   logic [wsd_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [wsd_pkg::ACT_W-1:0]      rem_ff, rem_in, trial;
   logic [4:0]                     bit_ff, bit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsd_pkg::L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      seed_ff  <= seed_in_r;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      lanes_ff <= lanes_in_r;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
   end

   always_comb begin
      state_in   = state_ff;
      seed_in_r  = seed_ff;
      p0_in      = p0_ff;
      p1_in      = p1_ff;
      p2_in      = p2_ff;
      lanes_in_r = lanes_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      bit_in     = bit_ff;
      done       = 1'b0;
      trial      = {rem_ff[wsd_pkg::ACT_W-2:0], quo_ff[wsd_pkg::DIVIDEND_W-1]};
      unique case (state_ff)
         wsd_pkg::L_IDLE: begin
            if (start) begin
               seed_in_r  = seed_in;
               lanes_in_r = lanes_in;
               state_in   = wsd_pkg::L_M0;
            end
         end
         wsd_pkg::L_M0: begin
            p0_in    = 64'(seed_ff[31:0]) * 64'(wsd_pkg::LCG_MUL[31:0]);
            state_in = wsd_pkg::L_M1;
         end
         wsd_pkg::L_M1: begin
            p1_in    = 32'(seed_ff[63:32] * wsd_pkg::LCG_MUL[31:0]);
            state_in = wsd_pkg::L_M2;
         end
         wsd_pkg::L_M2: begin
            p2_in    = 32'(seed_ff[31:0] * wsd_pkg::LCG_MUL[63:32]);
            state_in = wsd_pkg::L_SUM;
         end
         wsd_pkg::L_SUM: begin
            // cross terms only reach the upper word mod 2^64
            seed_in_r = p0_ff + {p1_ff + p2_ff, 32'd0} + wsd_pkg::LCG_ADD;
            quo_in    = seed_in_r[wsd_pkg::SEED_W-1:33];
            rem_in    = '0;
            bit_in    = '0;
            state_in  = wsd_pkg::L_DIV;
         end
         wsd_pkg::L_DIV: begin
            rem_in = (trial >= lanes_ff) ? trial - lanes_ff : trial;
            quo_in = {quo_ff[wsd_pkg::DIVIDEND_W-2:0], 1'b0};
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'(wsd_pkg::DIVIDEND_W - 1)) begin
               state_in = wsd_pkg::L_DONE;
            end
         end
         wsd_pkg::L_DONE: begin
            done     = 1'b1;
            state_in = wsd_pkg::L_IDLE;
         end
         default: state_in = wsd_pkg::L_IDLE;
      endcase
      result.seed   = seed_ff;
      result.offset = rem_ff[wsd_pkg::LANE_W-1:0];
   end
endmodule
`default_nettype wire

// ----- sv/wsd_checker.sv -----
// Port-level checks for the work-stealing task deques, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module wsd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);
   // a stalled result item is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

   // failed operations carry no handle and no source lane
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != wsd_pkg::ST_DONE |-> rsp_tdata[19:2] == 18'd0)
      else $error("failed result carries payload");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] <= wsd_pkg::ST_FULL && rsp_tdata[23:20] == 4'd0)
      else $error("bad status or padding");

   // clearing pass keeps input closed right after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !req_tready && !rsp_tvalid)
      else $error("block open during clearing pass");
endmodule

bind work_stealing_task_deques wsd_checker u_wsd_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the work-stealing task deques: stream driver, predictor and checker.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   typedef struct packed {
      logic [wsd_pkg::TASK_W-1:0] handle;
      logic [wsd_pkg::LANE_W-1:0] lane;
      logic [1:0]                 op;
   } req_item_type;

   typedef struct packed {
      logic [wsd_pkg::LANE_W-1:0] src;
      logic [wsd_pkg::TASK_W-1:0] task_id;
      logic [1:0]                 status;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;
   logic        req_taken = 1'b0;

   work_stealing_task_deques uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [wsd_pkg::CNT_W-1:0]  top_cnt [wsd_pkg::LANES];
   logic [wsd_pkg::CNT_W-1:0]  bot_cnt [wsd_pkg::LANES];
   logic [wsd_pkg::TASK_W-1:0] ring [wsd_pkg::LANES][wsd_pkg::SLOTS];
   logic [wsd_pkg::SEED_W-1:0] seed [wsd_pkg::LANES];
   logic [wsd_pkg::ACT_W-1:0]  lanes_active;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int errors = 0;
   int rsp_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;
   int steals_hit = 0;

   function automatic logic [wsd_pkg::CNT_W-1:0] occ(int l);
      return bot_cnt[l] - top_cnt[l];
   endfunction

   function automatic rsp_item_type deque_predict(req_item_type r);
      rsp_item_type o;
      int count, offset, v;
      logic [wsd_pkg::SEED_W-1:0] s;
      o = '{src: '0, task_id: '0, status: wsd_pkg::ST_EMPTY};
      count = (lanes_active > wsd_pkg::LANES) ? wsd_pkg::LANES : lanes_active;
      case (r.op)
         wsd_pkg::OP_PUSH: begin
            if (occ(r.lane) >= wsd_pkg::SLOTS) o.status = wsd_pkg::ST_FULL;
            else begin
               ring[r.lane][bot_cnt[r.lane][wsd_pkg::SLOT_W-1:0]] = r.handle;
               bot_cnt[r.lane] = bot_cnt[r.lane] + 1'b1;
               o.status = wsd_pkg::ST_DONE;
            end
         end
         wsd_pkg::OP_POP: begin
            if (occ(r.lane) == 1) begin
               o.task_id = ring[r.lane][top_cnt[r.lane][wsd_pkg::SLOT_W-1:0]];
               top_cnt[r.lane] = top_cnt[r.lane] + 1'b1;
               o.status = wsd_pkg::ST_DONE; o.src = r.lane;
            end else if (occ(r.lane) > 1) begin
               bot_cnt[r.lane] = bot_cnt[r.lane] - 1'b1;
               o.task_id = ring[r.lane][bot_cnt[r.lane][wsd_pkg::SLOT_W-1:0]];
               o.status = wsd_pkg::ST_DONE; o.src = r.lane;
            end
         end
         wsd_pkg::OP_STEAL: begin
            if (count >= 2) begin
               s = seed[r.lane] * wsd_pkg::LCG_MUL + wsd_pkg::LCG_ADD;
               seed[r.lane] = s;
               offset = int'((s >> 33) % count);
               for (int k = 0; k < count; k++) begin
                  v = offset + k;
                  if (v >= count) v -= count;
                  if (v != r.lane && occ(v) != 0 && o.status != wsd_pkg::ST_DONE) begin
                     o.task_id = ring[v][top_cnt[v][wsd_pkg::SLOT_W-1:0]];
                     top_cnt[v] = top_cnt[v] + 1'b1;
                     o.status = wsd_pkg::ST_DONE; o.src = wsd_pkg::LANE_W'(v);
                  end
               end
               if (o.status == wsd_pkg::ST_DONE) steals_hit++;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // accept seen at the rising edge: predict right away
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         req_taken = 1'b1;
         expected_rsps.push_back(deque_predict(pending_reqs.pop_front()));
      end
   end

   // driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0, pending_reqs[0]};
         end else req_tvalid <= 1'b0;
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            hold_off <= hold_off - 1;
         end else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_item_type'(rsp_tdata[19:0]);
         rsp_count++;
         if (rsp_tdata[23:20] != 0 || expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item %h", $time, rsp_tdata);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: mismatch exp status=%0d task=%h src=%0d, %s%0d task=%h src=%0d",
                        $time, want.status, want.task_id, want.src,
                        "got status=", got.status, got.task_id, got.src);
            end
         end
      end
   end

   task automatic add_req(logic [1:0] op, int lane, int h);
      req_item_type r;
      r.op = op; r.lane = wsd_pkg::LANE_W'(lane); r.handle = wsd_pkg::TASK_W'(h);
      pending_reqs.push_back(r);
   endtask

   // queue empty, the last accept already predicted and every result checked
   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_lanes(int n);
      @(negedge clock);
      csr_valid <= 1'b1; csr_data <= wsd_pkg::ACT_W'(n);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      lanes_active = wsd_pkg::ACT_W'(n);
   endtask

   task automatic random_phase(int n, int lim);
      int r, lane;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         lane = (lim > 1 && $urandom_range(3) != 0) ? $urandom_range(lim - 1)
                                                    : $urandom_range(63);
         if (r < 45) add_req(wsd_pkg::OP_PUSH, lane, $urandom_range(4095));
         else if (r < 65) add_req(wsd_pkg::OP_POP, lane, $urandom_range(4095));
         else if (r < 97) add_req(wsd_pkg::OP_STEAL, lane, $urandom_range(4095));
         else add_req(wsd_pkg::OP_NOP, lane, $urandom_range(4095));
      end
   endtask

   initial begin
      for (int l = 0; l < wsd_pkg::LANES; l++) begin
         top_cnt[l] = '0; bot_cnt[l] = '0;
         seed[l] = wsd_pkg::SEED_BASE * 64'(l + 1);
         for (int s = 0; s < wsd_pkg::SLOTS; s++) ring[l][s] = '0;
      end
      lanes_active = wsd_pkg::ACT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empties, extremes, steal with default two lanes, no-op code
      add_req(wsd_pkg::OP_POP, 0, 0);
      add_req(wsd_pkg::OP_STEAL, 0, 4095);
      add_req(wsd_pkg::OP_PUSH, 63, 4095);
      add_req(wsd_pkg::OP_PUSH, 63, 0);
      add_req(wsd_pkg::OP_POP, 63, 0);
      add_req(wsd_pkg::OP_POP, 63, 0);
      add_req(wsd_pkg::OP_POP, 63, 0);
      add_req(wsd_pkg::OP_PUSH, 1, 12'hA5A);
      add_req(wsd_pkg::OP_PUSH, 1, 12'h5A5);
      add_req(wsd_pkg::OP_STEAL, 0, 0);
      add_req(wsd_pkg::OP_STEAL, 1, 0);
      add_req(wsd_pkg::OP_STEAL, 40, 0);
      add_req(wsd_pkg::OP_NOP, 1, 12'hFFF);
      add_req(wsd_pkg::OP_POP, 1, 0);
      drain();

      // fill one lane past capacity to hit the full refusal
      for (int i = 0; i < wsd_pkg::SLOTS + 2; i++) add_req(wsd_pkg::OP_PUSH, 5, i);
      drain();
      write_lanes(1);
      add_req(wsd_pkg::OP_STEAL, 0, 0);
      drain();
      write_lanes(64);
      add_req(wsd_pkg::OP_STEAL, 63, 0);
      add_req(wsd_pkg::OP_STEAL, 5, 0);
      drain();
      write_lanes(127);
      random_phase(150, 64);
      drain();

      write_lanes(4);
      random_phase(250, 4);
      drain();
      write_lanes(8);
      send_idle_pct = 81;
      random_phase(150, 8);
      drain();
      send_idle_pct = 0; recv_stall_pct = 81;
      write_lanes(16);
      random_phase(150, 16);
      drain();
      send_idle_pct = 25; recv_stall_pct = 25;
      write_lanes(2);
      random_phase(150, 2);
      drain();

      // long receiver hold-off while items keep coming
      send_idle_pct = 0; recv_stall_pct = 0;
      write_lanes(3);
      random_phase(100, 3);
      hold_off = 400;
      drain();

      $display("Covered push/pop/steal over lane counts 1..127 with idling, full lanes and backpressure;");
      $display("%0d results checked, %0d successful steals.", rsp_count, steals_hit);
      if (errors == 0) $display("** work_stealing_task_deques: PASSED **");
      else $display("** work_stealing_task_deques: FAILED **");
      $finish;
   end

   initial begin
      #8000000;
      $display("** work_stealing_task_deques: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
